>>> hw/rtl/rbst_pkg.sv
// rbst_pkg: shared constants and types for the ray/box slab test.
// No dependencies; used by every module of the block.
`default_nettype none
package rbst_pkg;

  // Fixed-point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = 33;               // bound - origin, signed
  localparam int NUM_W     = DIFF_W + FRAC_BITS; // scaled numerator magnitude
  localparam int LANE_LAT  = NUM_W + 2;        // prep + divider + saturate
  localparam int MERGE_LAT = 2;
  localparam int NUM_AXES  = 3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic [30:0] T_MIN_RST = 31'd1;

  // One lane's finding for one axis
  typedef struct packed {
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
    logic               zero_dir;
    logic               in_slab;
  } rbst_lane_t;

endpackage
`default_nettype wire

>>> hw/rtl/rbst_div.sv
// rbst_div: pipelined restoring divider, one quotient bit per stage.
// Unsigned magnitudes in, magnitude quotient and sign flag out; uses rbst_pkg.
`default_nettype none
module rbst_div (
  input  wire logic                      clk,
  input  wire logic [rbst_pkg::NUM_W-1:0] num_i,
  input  wire logic [31:0]               dmag_i,
  input  wire logic                      neg_i,
  output logic      [rbst_pkg::NUM_W-1:0] quo_o,
  output logic                           neg_o
);
  import rbst_pkg::*;

  logic [31:0]      rem_r  [NUM_W];
  logic [NUM_W-1:0] num_r  [NUM_W];
  logic [NUM_W-1:0] quo_r  [NUM_W];
  logic [31:0]      dmag_r [NUM_W];
  logic             neg_r  [NUM_W];

  // One stage per quotient bit, MSB first
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [31:0]      rem_p;
    logic [NUM_W-1:0] num_p;
    logic [NUM_W-1:0] quo_p;
    logic [31:0]      dmag_p;
    logic             neg_p;
    logic [32:0]      trial;
    logic             ge;
    logic [32:0]      diff;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign num_p  = num_i;
      assign quo_p  = '0;
      assign dmag_p = dmag_i;
      assign neg_p  = neg_i;
    end else begin : g_next
      assign rem_p  = rem_r[s-1];
      assign num_p  = num_r[s-1];
      assign quo_p  = quo_r[s-1];
      assign dmag_p = dmag_r[s-1];
      assign neg_p  = neg_r[s-1];
    end

    assign trial = {rem_p, num_p[NUM_W-1]};
    assign ge    = (trial >= {1'b0, dmag_p});
    assign diff  = trial - {1'b0, dmag_p};

    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? diff[31:0] : trial[31:0];
      num_r[s]  <= {num_p[NUM_W-2:0], 1'b0};
      quo_r[s]  <= {quo_p[NUM_W-2:0], ge};
      dmag_r[s] <= dmag_p;
      neg_r[s]  <= neg_p;
    end
  end

  assign quo_o = quo_r[NUM_W-1];
  assign neg_o = neg_r[NUM_W-1];

endmodule
`default_nettype wire

>>> hw/rtl/rbst_lane.sv
// rbst_lane: slab distances for one axis (two dividers, saturate, order).
// Depends on rbst_pkg and rbst_div.
`default_nettype none
module rbst_lane (
  input  wire logic               clk,
  input  wire logic signed [31:0] lo_i,
  input  wire logic signed [31:0] hi_i,
  input  wire logic signed [31:0] org_i,
  input  wire logic signed [31:0] dir_i,
  output rbst_pkg::rbst_lane_t    res_o
);
  import rbst_pkg::*;

  logic signed [DIFF_W-1:0] diff_a, diff_b;
  logic [DIFF_W-1:0]        mag_a, mag_b;
  logic [31:0]              dmag;

  logic [NUM_W-1:0] num_a_r, num_b_r;
  logic             neg_a_r, neg_b_r;
  logic [31:0]      dmag_r;
  logic             zero_r, inside_r;

  logic [NUM_W-1:0] quo_a, quo_b;
  logic             neg_a, neg_b;
  logic             zero_sh_r   [NUM_W];
  logic             inside_sh_r [NUM_W];

  logic signed [31:0] t_a, t_b;
  rbst_lane_t         res_r;

  // Prep: differences, magnitudes, quotient signs
  assign diff_a = DIFF_W'(lo_i) - DIFF_W'(org_i);
  assign diff_b = DIFF_W'(hi_i) - DIFF_W'(org_i);
  assign mag_a  = diff_a[DIFF_W-1] ? -diff_a : diff_a;
  assign mag_b  = diff_b[DIFF_W-1] ? -diff_b : diff_b;
  assign dmag   = dir_i[31] ? -dir_i : dir_i;

  always_ff @(posedge clk) begin
    num_a_r  <= {mag_a, {FRAC_BITS{1'b0}}};
    num_b_r  <= {mag_b, {FRAC_BITS{1'b0}}};
    neg_a_r  <= diff_a[DIFF_W-1] ^ dir_i[31];
    neg_b_r  <= diff_b[DIFF_W-1] ^ dir_i[31];
    dmag_r   <= dmag;
    zero_r   <= (dir_i == '0);
    inside_r <= (org_i >= lo_i) && (org_i <= hi_i);
  end

  rbst_div u_div_a (
    .clk(clk), .num_i(num_a_r), .dmag_i(dmag_r), .neg_i(neg_a_r),
    .quo_o(quo_a), .neg_o(neg_a)
  );
  rbst_div u_div_b (
    .clk(clk), .num_i(num_b_r), .dmag_i(dmag_r), .neg_i(neg_b_r),
    .quo_o(quo_b), .neg_o(neg_b)
  );

  // Zero-direction and inside-slab flags ride alongside the dividers
  for (genvar s = 0; s < NUM_W; s++) begin : g_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        zero_sh_r[s]   <= zero_r;
        inside_sh_r[s] <= inside_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        zero_sh_r[s]   <= zero_sh_r[s-1];
        inside_sh_r[s] <= inside_sh_r[s-1];
      end
    end
  end

  // Signed saturation of a magnitude quotient
  function automatic logic signed [31:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
    logic over_neg;
    logic over_pos;
    over_neg = (|q[NUM_W-1:32]) || (q[31] && (|q[30:0]));
    over_pos = |q[NUM_W-1:31];
    if (neg) begin
      sat_q = over_neg ? Q_MIN : -q[31:0];
    end else begin
      sat_q = over_pos ? Q_MAX : q[31:0];
    end
  endfunction

  assign t_a = sat_q(quo_a, neg_a);
  assign t_b = sat_q(quo_b, neg_b);

  // Order near/far; a flat axis contributes neutral limits
  always_ff @(posedge clk) begin
    res_r.zero_dir <= zero_sh_r[NUM_W-1];
    res_r.in_slab  <= inside_sh_r[NUM_W-1];
    if (zero_sh_r[NUM_W-1]) begin
      res_r.t_near <= Q_MIN;
      res_r.t_far  <= Q_MAX;
    end else if (t_a < t_b) begin
      res_r.t_near <= t_a;
      res_r.t_far  <= t_b;
    end else begin
      res_r.t_near <= t_b;
      res_r.t_far  <= t_a;
    end
  end

  assign res_o = res_r;

endmodule
`default_nettype wire

>>> hw/rtl/rbst_merge.sv
// rbst_merge: combines the three lane results into the hit word.
// Depends on rbst_pkg.
`default_nettype none
module rbst_merge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 valid_i,
  input  rbst_pkg::rbst_lane_t      lane_i [rbst_pkg::NUM_AXES],
  input  wire logic [30:0]          t_min_i,
  output logic                      valid_o,
  output logic                      hit_o
);
  import rbst_pkg::*;

  logic signed [31:0] near_nxt, far_nxt;
  logic               bad_nxt;
  logic signed [31:0] near_r, far_r;
  logic               bad_r;
  logic               v1_r, v2_r, hit_r;

  // Largest near, smallest far, flat axes outside the box
  always_comb begin
    near_nxt = {1'b0, t_min_i};
    far_nxt  = Q_MAX;
    bad_nxt  = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (lane_i[a].t_near > near_nxt) near_nxt = lane_i[a].t_near;
      if (lane_i[a].t_far < far_nxt)   far_nxt  = lane_i[a].t_far;
      if (lane_i[a].zero_dir && !lane_i[a].in_slab) bad_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    near_r <= near_nxt;
    far_r  <= far_nxt;
    bad_r  <= bad_nxt;
    hit_r  <= !bad_r && (near_r <= far_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  assign valid_o = v2_r;
  assign hit_o   = hit_r;

`ifndef SYNTHESIS
  a_bad_miss: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && bad_r |=> valid_o && !hit_o)
    else $error("flat axis outside box reported as hit");
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !bad_r && (near_r > far_r) |=> !hit_o)
    else $error("hit with near beyond far");
  a_valid_lat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o |-> $past(v1_r))
    else $error("merge valid without stage-one valid");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/ray_box_slab_test.sv
// ray_box_slab_test: top level, three axis lanes and the merge stage.
// Depends on rbst_pkg, rbst_lane, rbst_merge.
`default_nettype none
// Fully pipelined: one ray/box word is taken every clock (busy is low except
// in reset). Its hit word is strobed on out_valid/out_hit once it has passed
// the lane prep register, the dividers, the lane order register and the
// merge registers. The dividers are bit-per-stage, two per axis lane, each
// 49 stages deep. Results cannot be held
// off; the receiver must take each word in the cycle it is strobed.
// Write cfg_wdata (t_min) only while no word is in flight.
module ray_box_slab_test (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_box_min_x,
  input  wire logic signed [31:0] in_box_min_y,
  input  wire logic signed [31:0] in_box_min_z,
  input  wire logic signed [31:0] in_box_max_x,
  input  wire logic signed [31:0] in_box_max_y,
  input  wire logic signed [31:0] in_box_max_z,
  input  wire logic signed [31:0] in_origin_x,
  input  wire logic signed [31:0] in_origin_y,
  input  wire logic signed [31:0] in_origin_z,
  input  wire logic signed [31:0] in_dir_x,
  input  wire logic signed [31:0] in_dir_y,
  input  wire logic signed [31:0] in_dir_z,
  output logic                    out_valid,
  output logic                    out_hit,
  input  wire logic               cfg_we,
  input  wire logic [30:0]        cfg_wdata
);
  import rbst_pkg::*;

  logic        accept;
  logic [30:0] t_min_r;
  logic        vld_r [LANE_LAT];
  rbst_lane_t  lane_res [NUM_AXES];

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_min_r <= T_MIN_RST;
    end else if (cfg_we) begin
      t_min_r <= cfg_wdata;
    end
  end

  // Valid tracking through the lanes
  for (genvar s = 0; s < LANE_LAT; s++) begin : g_vld
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= accept;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  rbst_lane u_lane_x (
    .clk(clk), .lo_i(in_box_min_x), .hi_i(in_box_max_x),
    .org_i(in_origin_x), .dir_i(in_dir_x), .res_o(lane_res[0])
  );
  rbst_lane u_lane_y (
    .clk(clk), .lo_i(in_box_min_y), .hi_i(in_box_max_y),
    .org_i(in_origin_y), .dir_i(in_dir_y), .res_o(lane_res[1])
  );
  rbst_lane u_lane_z (
    .clk(clk), .lo_i(in_box_min_z), .hi_i(in_box_max_z),
    .org_i(in_origin_z), .dir_i(in_dir_z), .res_o(lane_res[2])
  );

  rbst_merge u_merge (
    .clk(clk), .rst_n(rst_n), .valid_i(vld_r[LANE_LAT-1]),
    .lane_i(lane_res), .t_min_i(t_min_r),
    .valid_o(out_valid), .hit_o(out_hit)
  );

endmodule
`default_nettype wire
